[sv/psu_pkg.sv]
// shared types and constants of the preset slot store
package psu_pkg;

    // field widths and knob count fixed by the item format
    localparam int KNOB_W     = 16;
    localparam int KNOB_COUNT = 8;
    localparam int SLOT_IDX_W = 4;

    // operation codes of an input item
    typedef enum logic [2:0] {
        OP_SAVE        = 3'd0,
        OP_LOAD        = 3'd1,
        OP_NEXT        = 3'd2,
        OP_PREV        = 3'd3,
        OP_NEXT_ACTIVE = 3'd4,
        OP_PREV_ACTIVE = 3'd5,
        OP_SELECT      = 3'd6,
        OP_RANDOM      = 3'd7
    } op_t;

    // value register control from the sequencer
    typedef struct packed {
        logic load;  // a result is produced this cycle
        logic take;  // use the read row, else clear the values
    } val_ctrl_t;

endpackage

[sv/psu_ram.sv]
// generic single write port ram with registered read
module psu_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/psu_ctrl.sv]
// slot pointer, in-use flags and operation sequencer of the preset slot store
module psu_ctrl #(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_W     = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     opcode,
    input  logic [psu_pkg::SLOT_IDX_W-1:0] slot_index,
    input  logic                           go_forward,
    output logic                           mem_we,
    output logic [SLOT_W-1:0]              mem_waddr,
    output logic [SLOT_W-1:0]              mem_raddr,
    output psu_pkg::val_ctrl_t             vctl,
    output logic                           done,
    output logic [SLOT_W-1:0]              cur_slot,
    output logic                           slot_in_use,
    output logic                           values_loaded
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEEK = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic [SLOT_W-1:0]       scan_reg, scan_next;
    logic                    fwd_reg, fwd_next;
    logic [SLOT_COUNT-1:0]   flags_reg, flags_next;
    logic                    any_reg, any_next;
    logic                    done_reg, done_next;
    logic                    in_use_reg, in_use_next;
    logic                    loaded_reg, loaded_next;
    logic [SLOT_W-1:0]       target;
    logic                    dir;
    psu_pkg::op_t            op;

    // circular step of a slot index
    function automatic logic [SLOT_W-1:0] step_slot(input logic [SLOT_W-1:0] s,
                                                    input logic fwd);
        logic [SLOT_W-1:0] r;
        if (fwd)
        begin
            r = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
        end
        else
        begin
            r = (s == '0) ? SLOT_W'(SLOT_COUNT - 1) : s - 1'b1;
        end
        return r;
    endfunction

    assign op = psu_pkg::op_t'(opcode);

    // select target, saturated to the last slot
    always_comb
    begin
        if (int'(slot_index) >= SLOT_COUNT)
        begin
            target = SLOT_W'(SLOT_COUNT - 1);
        end
        else
        begin
            target = SLOT_W'(slot_index);
        end
    end

    // search direction: fixed for next and prev active, go_forward for the others
    always_comb
    begin
        unique case (op)
            psu_pkg::OP_NEXT_ACTIVE: dir = 1'b1;
            psu_pkg::OP_PREV_ACTIVE: dir = 1'b0;
            default:                 dir = go_forward;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        scan_next   = scan_reg;
        fwd_next    = fwd_reg;
        flags_next  = flags_reg;
        any_next    = any_reg;
        done_next   = 1'b0;
        in_use_next = in_use_reg;
        loaded_next = loaded_reg;
        mem_we      = 1'b0;
        mem_raddr   = cur_reg;
        vctl.load   = 1'b0;
        vctl.take   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        psu_pkg::OP_SAVE:
                        begin
                            mem_we              = 1'b1;
                            flags_next[cur_reg] = 1'b1;
                            any_next            = 1'b1;
                            done_next           = 1'b1;
                            in_use_next         = 1'b1;
                            loaded_next         = 1'b0;
                            vctl.load           = 1'b1;
                        end
                        psu_pkg::OP_LOAD:
                        begin
                            state_next = ST_READ;
                        end
                        psu_pkg::OP_NEXT, psu_pkg::OP_PREV:
                        begin
                            cur_next    = step_slot(cur_reg, op == psu_pkg::OP_NEXT);
                            done_next   = 1'b1;
                            in_use_next = flags_reg[cur_next];
                            loaded_next = 1'b0;
                            vctl.load   = 1'b1;
                        end
                        psu_pkg::OP_NEXT_ACTIVE, psu_pkg::OP_PREV_ACTIVE,
                        psu_pkg::OP_RANDOM:
                        begin
                            // with no slot in use the current slot is loaded
                            if (any_reg)
                            begin
                                scan_next  = step_slot(cur_reg, dir);
                                fwd_next   = dir;
                                state_next = ST_SEEK;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        psu_pkg::OP_SELECT:
                        begin
                            if (target != cur_reg)
                            begin
                                cur_next   = target;
                                mem_raddr  = target;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                in_use_next = flags_reg[cur_reg];
                                loaded_next = 1'b0;
                                vctl.load   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_SEEK:
            begin
                // one slot tested per cycle, always ends since a flag is set
                mem_raddr = scan_reg;
                if (flags_reg[scan_reg])
                begin
                    cur_next   = scan_reg;
                    state_next = ST_READ;
                end
                else
                begin
                    scan_next = step_slot(scan_reg, fwd_reg);
                end
            end
            ST_READ:
            begin
                // row data is valid now; a slot not in use gives values cleared to zero
                done_next   = 1'b1;
                in_use_next = flags_reg[cur_reg];
                loaded_next = 1'b1;
                vctl.load   = 1'b1;
                vctl.take   = flags_reg[cur_reg];
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cur_reg    <= '0;
            scan_reg   <= '0;
            fwd_reg    <= 1'b0;
            flags_reg  <= '0;
            any_reg    <= 1'b0;
            done_reg   <= 1'b0;
            in_use_reg <= 1'b0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            scan_reg   <= scan_next;
            fwd_reg    <= fwd_next;
            flags_reg  <= flags_next;
            any_reg    <= any_next;
            done_reg   <= done_next;
            in_use_reg <= in_use_next;
            loaded_reg <= loaded_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign mem_waddr     = cur_reg;
    assign done          = done_reg;
    assign cur_slot      = cur_reg;
    assign slot_in_use   = in_use_reg;
    assign values_loaded = loaded_reg;

endmodule

[sv/preset_slot_store_unit.sv]
// top level of the preset slot store: slot row ram, sequencer and result registers
//
// usage: drive opcode, slot_index, go_forward and knob_0..knob_7 and raise start;
// the item is taken at a rising edge with start high and busy low. each item
// gives one result, shown for exactly one cycle with done high; the receiver
// cannot stall and must take it in that cycle.
// from accept to done:
//   save, next, prev, select of the current slot: done follows in the next
//   cycle, busy stays low, so one item per cycle
//   load, select of another slot, active search with no slot in use: the read
//   state, then done; active search: the seek state tests one flag per cycle
//   over the circular distance k (1 to SLOT_COUNT) to the slot found, then read
// a save writes one row and a load takes one row read through the single slot ram.
// reset empties the store at once: the in-use flags clear, and a slot that is
// not in use reads as all zero, so the ram needs no clearing pass. the pointer
// returns to slot zero.
module preset_slot_store_unit #(
    parameter int SLOT_COUNT = 16,
    parameter int ROW_COUNT  = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic [3:0]         slot_index,
    input  logic               go_forward,
    input  logic signed [15:0] knob_0,
    input  logic signed [15:0] knob_1,
    input  logic signed [15:0] knob_2,
    input  logic signed [15:0] knob_3,
    input  logic signed [15:0] knob_4,
    input  logic signed [15:0] knob_5,
    input  logic signed [15:0] knob_6,
    input  logic signed [15:0] knob_7,
    output logic               done,
    output logic signed [15:0] value_0,
    output logic signed [15:0] value_1,
    output logic signed [15:0] value_2,
    output logic signed [15:0] value_3,
    output logic signed [15:0] value_4,
    output logic signed [15:0] value_5,
    output logic signed [15:0] value_6,
    output logic signed [15:0] value_7,
    output logic [3:0]         current_slot,
    output logic               slot_in_use,
    output logic               values_loaded
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int ROW_W  = ROW_COUNT * psu_pkg::KNOB_W;

    logic [psu_pkg::KNOB_COUNT-1:0][psu_pkg::KNOB_W-1:0] knob_all;
    logic [psu_pkg::KNOB_COUNT-1:0][psu_pkg::KNOB_W-1:0] rd_ext;
    logic [psu_pkg::KNOB_COUNT-1:0][psu_pkg::KNOB_W-1:0] value_reg, value_next;
    logic [ROW_COUNT-1:0][psu_pkg::KNOB_W-1:0]           wdata;
    logic [ROW_COUNT-1:0][psu_pkg::KNOB_W-1:0]           rdata;
    logic                                                mem_we;
    logic [SLOT_W-1:0]                                   mem_waddr;
    logic [SLOT_W-1:0]                                   mem_raddr;
    logic [SLOT_W-1:0]                                   cur_slot;
    psu_pkg::val_ctrl_t                                  vctl;

    // knob rows to store, knobs beyond the row count dropped
    assign knob_all = {knob_7, knob_6, knob_5, knob_4, knob_3, knob_2, knob_1, knob_0};
    assign wdata    = knob_all[ROW_COUNT-1:0];

    psu_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wdata),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    psu_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .slot_index    (slot_index),
        .go_forward    (go_forward),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_raddr     (mem_raddr),
        .vctl          (vctl),
        .done          (done),
        .cur_slot      (cur_slot),
        .slot_in_use   (slot_in_use),
        .values_loaded (values_loaded)
    );

    // read row widened to all value ports, missing rows zero
    always_comb
    begin
        rd_ext                = '0;
        rd_ext[ROW_COUNT-1:0] = rdata;
    end

    // value result registers
    always_comb
    begin
        value_next = value_reg;
        if (vctl.load)
        begin
            value_next = vctl.take ? rd_ext : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_0      = value_reg[0];
    assign value_1      = value_reg[1];
    assign value_2      = value_reg[2];
    assign value_3      = value_reg[3];
    assign value_4      = value_reg[4];
    assign value_5      = value_reg[5];
    assign value_6      = value_reg[6];
    assign value_7      = value_reg[7];
    assign current_slot = 4'(cur_slot);

endmodule

[sim/tb_preset_slot_store_unit.sv]
// self-checking testbench of the preset slot store top level
module tb_preset_slot_store_unit;

    localparam int SLOTS        = 16;
    localparam int ROWS         = 8;
    localparam int STALL_LIMIT  = 256;
    localparam int DRAIN_CYCLES = 24;
    localparam int PRINT_LIMIT  = 40;

    // knob patterns for the saves of the directed part
    localparam logic [psu_pkg::KNOB_COUNT-1:0][psu_pkg::KNOB_W-1:0] KNOBS_EDGE = {
        16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
        16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA
    };
    localparam logic [psu_pkg::KNOB_COUNT-1:0][psu_pkg::KNOB_W-1:0] KNOBS_FLIP = ~KNOBS_EDGE;

    typedef struct packed {
        psu_pkg::op_t                                        op;
        logic [psu_pkg::SLOT_IDX_W-1:0]                      slot_index;
        logic                                                go_forward;
        logic [psu_pkg::KNOB_COUNT-1:0][psu_pkg::KNOB_W-1:0] knob;
    } preset_item_t;

    typedef struct packed {
        logic [psu_pkg::KNOB_COUNT-1:0][psu_pkg::KNOB_W-1:0] value;
        logic [psu_pkg::SLOT_IDX_W-1:0]                      slot;
        logic                                                in_use;
        logic                                                loaded;
    } preset_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [2:0]                opcode;
    logic [3:0]                slot_index;
    logic                      go_forward;
    logic signed [15:0]        knob_0, knob_1, knob_2, knob_3;
    logic signed [15:0]        knob_4, knob_5, knob_6, knob_7;
    logic                      done;
    logic signed [15:0]        value_0, value_1, value_2, value_3;
    logic signed [15:0]        value_4, value_5, value_6, value_7;
    logic [3:0]                current_slot;
    logic                      slot_in_use;
    logic                      values_loaded;

    // predicted store contents
    logic [psu_pkg::KNOB_W-1:0]     slot_mem [SLOTS][ROWS];
    bit                             slot_used [SLOTS];
    logic [psu_pkg::SLOT_IDX_W-1:0] slot_ptr;

    preset_result_t            pending_results [$];
    int                        mismatch_count;
    int                        stall_cycles;
    bit                        idle_on;

    preset_slot_store_unit #(
        .SLOT_COUNT(SLOTS),
        .ROW_COUNT (ROWS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .slot_index   (slot_index),
        .go_forward   (go_forward),
        .knob_0       (knob_0),
        .knob_1       (knob_1),
        .knob_2       (knob_2),
        .knob_3       (knob_3),
        .knob_4       (knob_4),
        .knob_5       (knob_5),
        .knob_6       (knob_6),
        .knob_7       (knob_7),
        .done         (done),
        .value_0      (value_0),
        .value_1      (value_1),
        .value_2      (value_2),
        .value_3      (value_3),
        .value_4      (value_4),
        .value_5      (value_5),
        .value_6      (value_6),
        .value_7      (value_7),
        .current_slot (current_slot),
        .slot_in_use  (slot_in_use),
        .values_loaded(values_loaded)
    );

    // clock, period 8
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // circular search for an in-use slot, pointer stays if none is in use
    function automatic void seek_used_slot(input logic forward);
        bit                             any_used;
        logic [psu_pkg::SLOT_IDX_W-1:0] s;
        any_used = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            any_used = any_used | slot_used[i];
        if (!any_used)
            return;
        s = slot_ptr;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (forward)
                s = (s == SLOTS - 1) ? '0 : s + 1'b1;
            else
                s = (s == 0) ? psu_pkg::SLOT_IDX_W'(SLOTS - 1) : s - 1'b1;
            if (slot_used[s])
            begin
                slot_ptr = s;
                return;
            end
        end
    endfunction

    // applies one operation to the predicted store and gives its result
    function automatic preset_result_t predict_preset_op(input preset_item_t it);
        preset_result_t                 res;
        logic [psu_pkg::SLOT_IDX_W-1:0] target;
        res = '0;
        case (it.op)
            psu_pkg::OP_SAVE:
            begin
                for (int r = 0; r < ROWS; r++)
                    slot_mem[slot_ptr][r] = it.knob[r];
                slot_used[slot_ptr] = 1'b1;
            end
            psu_pkg::OP_LOAD:
                res.loaded = 1'b1;
            psu_pkg::OP_NEXT:
                slot_ptr = (slot_ptr == SLOTS - 1) ? '0 : slot_ptr + 1'b1;
            psu_pkg::OP_PREV:
                slot_ptr = (slot_ptr == 0) ? psu_pkg::SLOT_IDX_W'(SLOTS - 1)
                                           : slot_ptr - 1'b1;
            psu_pkg::OP_NEXT_ACTIVE:
            begin
                seek_used_slot(1'b1);
                res.loaded = 1'b1;
            end
            psu_pkg::OP_PREV_ACTIVE:
            begin
                seek_used_slot(1'b0);
                res.loaded = 1'b1;
            end
            psu_pkg::OP_SELECT:
            begin
                target = (it.slot_index > SLOTS - 1) ? psu_pkg::SLOT_IDX_W'(SLOTS - 1)
                                                     : it.slot_index;
                if (target != slot_ptr)
                begin
                    slot_ptr   = target;
                    res.loaded = 1'b1;
                end
            end
            default:
            begin
                seek_used_slot(it.go_forward);
                res.loaded = 1'b1;
            end
        endcase
        if (res.loaded)
            for (int r = 0; r < ROWS; r++)
                res.value[r] = slot_mem[slot_ptr][r];
        res.slot   = slot_ptr;
        res.in_use = slot_used[slot_ptr];
        return res;
    endfunction

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, 14)) : 0;
    endfunction

    function automatic preset_item_t build_item(
        input psu_pkg::op_t op, input logic [3:0] idx, input logic fwd,
        input logic [psu_pkg::KNOB_COUNT-1:0][psu_pkg::KNOB_W-1:0] kv);
        preset_item_t it;
        it.op         = op;
        it.slot_index = idx;
        it.go_forward = fwd;
        it.knob       = kv;
        return it;
    endfunction

    function automatic preset_item_t random_item(input psu_pkg::op_t op);
        logic [psu_pkg::KNOB_COUNT-1:0][psu_pkg::KNOB_W-1:0] kv;
        for (int r = 0; r < psu_pkg::KNOB_COUNT; r++)
            kv[r] = psu_pkg::KNOB_W'($urandom);
        return build_item(op, 4'($urandom), 1'($urandom), kv);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
        mismatch_count++;
    endtask

    // drives one item after a random gap and waits until it is taken
    task automatic send_item(input preset_item_t it);
        int gap;
        gap = draw_gap();
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        opcode     <= it.op;
        slot_index <= it.slot_index;
        go_forward <= it.go_forward;
        knob_0     <= it.knob[0];
        knob_1     <= it.knob[1];
        knob_2     <= it.knob[2];
        knob_3     <= it.knob[3];
        knob_4     <= it.knob[4];
        knob_5     <= it.knob[5];
        knob_6     <= it.knob[6];
        knob_7     <= it.knob[7];
        start      <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_preset_op(it));
    endtask

    // result check against the oldest prediction
    always @(posedge clk)
    begin : check_results
        preset_result_t want;
        preset_result_t got;
        if (rst_n && done)
        begin
            got.value  = {value_7, value_6, value_5, value_4,
                          value_3, value_2, value_1, value_0};
            got.slot   = current_slot;
            got.in_use = slot_in_use;
            got.loaded = values_loaded;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                for (int r = 0; r < ROWS; r++)
                    if (got.value[r] !== want.value[r])
                        report_mismatch($sformatf("value_%0d", r),
                                        int'($signed(got.value[r])),
                                        int'($signed(want.value[r])));
                if (got.slot !== want.slot)
                    report_mismatch("current_slot", int'(got.slot), int'(want.slot));
                if (got.in_use !== want.in_use)
                    report_mismatch("slot_in_use", int'(got.in_use), int'(want.in_use));
                if (got.loaded !== want.loaded)
                    report_mismatch("values_loaded", int'(got.loaded), int'(want.loaded));
            end
        end
    end

    // watchdog on cycles with neither an item taken nor a result shown
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic apply_reset();
        start      <= 1'b0;
        opcode     <= psu_pkg::OP_SAVE;
        slot_index <= '0;
        go_forward <= 1'b0;
        knob_0     <= '0;
        knob_1     <= '0;
        knob_2     <= '0;
        knob_3     <= '0;
        knob_4     <= '0;
        knob_5     <= '0;
        knob_6     <= '0;
        knob_7     <= '0;
        rst_n      <= 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_used[s] = 1'b0;
            for (int r = 0; r < ROWS; r++)
                slot_mem[s][r] = '0;
        end
        slot_ptr = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    endtask

    // extremes, wraparound, empty store and lone in-use slot searches
    task automatic test_directed();
        idle_on = 1'b1;
        // searches and load on the empty store
        send_item(build_item(psu_pkg::OP_LOAD,        4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_NEXT_ACTIVE, 4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_PREV_ACTIVE, 4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_RANDOM,      4'd0,  1'b1, '0));
        send_item(build_item(psu_pkg::OP_RANDOM,      4'd0,  1'b0, '0));
        // select of the current slot, then of the last slot, then wraparound steps
        send_item(build_item(psu_pkg::OP_SELECT,      4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_SELECT,      4'd15, 1'b0, '0));
        send_item(build_item(psu_pkg::OP_NEXT,        4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_PREV,        4'd0,  1'b0, '0));
        // only the current slot in use: searches go all the way round
        send_item(build_item(psu_pkg::OP_SAVE,        4'd0,  1'b0, KNOBS_EDGE));
        send_item(build_item(psu_pkg::OP_LOAD,        4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_NEXT_ACTIVE, 4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_PREV_ACTIVE, 4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_RANDOM,      4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_PREV,        4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_NEXT_ACTIVE, 4'd0,  1'b0, '0));
        // a second slot in use, searches both ways
        send_item(build_item(psu_pkg::OP_SELECT,      4'd3,  1'b1, '0));
        send_item(build_item(psu_pkg::OP_SAVE,        4'd3,  1'b1, KNOBS_FLIP));
        send_item(build_item(psu_pkg::OP_PREV_ACTIVE, 4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_NEXT_ACTIVE, 4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_RANDOM,      4'd0,  1'b1, '0));
        send_item(build_item(psu_pkg::OP_SELECT,      4'd15, 1'b0, '0));
        send_item(build_item(psu_pkg::OP_NEXT,        4'd0,  1'b0, '0));
        send_item(build_item(psu_pkg::OP_LOAD,        4'd0,  1'b0, '0));
    endtask

    // few saves so the searches cover long circular distances
    task automatic test_sparse_search(input int count);
        int           pick;
        psu_pkg::op_t op;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 2)        op = psu_pkg::OP_SAVE;
            else if (pick < 10)  op = psu_pkg::OP_LOAD;
            else if (pick < 25)  op = psu_pkg::OP_NEXT;
            else if (pick < 40)  op = psu_pkg::OP_PREV;
            else if (pick < 55)  op = psu_pkg::OP_NEXT_ACTIVE;
            else if (pick < 70)  op = psu_pkg::OP_PREV_ACTIVE;
            else if (pick < 85)  op = psu_pkg::OP_SELECT;
            else                 op = psu_pkg::OP_RANDOM;
            send_item(random_item(op));
        end
    endtask

    // all operations with regular saves and random knob values
    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_item(random_item(psu_pkg::op_t'($urandom_range(0, 7))));
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        idle_on        = 1'b1;
        apply_reset();
        test_directed();
        test_sparse_search(300);
        test_random_mix(600);
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
sv/psu_pkg.sv
sv/psu_ram.sv
sv/psu_ctrl.sv
sv/preset_slot_store_unit.sv
sim/tb_preset_slot_store_unit.sv
